### hw/rtl/i2cras_pkg.sv
// ----------------------------------------------------------------------------
// i2cras_pkg
// Types, bus action codes, status codes and reset values shared by the
// register access sequencer.
// ----------------------------------------------------------------------------
package i2cras_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_COMMAND = 1'd1;

  localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd13;
  localparam logic [7:0] POINTER_COMMAND_RST = 8'd176;

  // item kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // bus actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_STOP = 3'd4;
  localparam logic [2:0] ACT_STOP_START = 3'd5;
  localparam logic [2:0] ACT_RECV = 3'd6;
  localparam logic [2:0] ACT_CLR_TIMEOUT = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_STATUS = 2'd2;

  // controller status codes
  localparam logic [7:0] ST_START_SENT = 8'h08;
  localparam logic [7:0] ST_RESTART_SENT = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  localparam logic READ_BIT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic       is_read;
    logic [7:0] reg_address;
    logic [7:0] write_value;
    logic [7:0] bus_status;
    logic       timeout_seen;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic       done_res;
    logic [1:0] error_code;
    logic [7:0] read_data;
  } result_t;

  // handoff from the input register to the decoder
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

### hw/rtl/i2cras_req_if.sv
// ----------------------------------------------------------------------------
// i2cras_req_if
// Request channel: start commands and bus status events.
// ----------------------------------------------------------------------------
interface i2cras_req_if import i2cras_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/i2cras_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cras_rsp_if
// Response channel: bus action and access results.
// ----------------------------------------------------------------------------
interface i2cras_rsp_if import i2cras_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/i2cras_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cras_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cras_cfg_if import i2cras_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/i2cras_in_stage.sv
// ----------------------------------------------------------------------------
// i2cras_in_stage
// Input register for the request channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module i2cras_in_stage import i2cras_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  i2cras_req_if.sink   req,
  input  logic         take,
  output stage_t       stage
);

  logic  hold_valid;
  item_t hold_item;

  assign req.ready = !hold_valid || take;
  assign stage.valid = hold_valid;
  assign stage.item = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold_item <= req.data;
    end
  end

endmodule

### hw/rtl/i2cras_decode.sv
// ----------------------------------------------------------------------------
// i2cras_decode
// Configuration registers, access state and the per-item decode rule.
// ----------------------------------------------------------------------------
module i2cras_decode import i2cras_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  i2cras_cfg_if.sink   cfg,
  input  logic         fire,
  input  item_t        item,
  output result_t      result
);

  logic [6:0]  slave_address;
  logic [7:0]  pointer_command;

  logic [15:0] transfer_word;
  logic        read_mode;
  logic        second_byte_sent;
  logic        access_finished;
  logic [7:0]  received_byte;

  logic [15:0] transfer_word_next;
  logic        read_mode_next;
  logic        second_byte_sent_next;
  logic        access_finished_next;
  logic [7:0]  received_byte_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RST;
      pointer_command <= POINTER_COMMAND_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg.data[6:0];
        CFG_POINTER_COMMAND: pointer_command <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    transfer_word_next = transfer_word;
    read_mode_next = read_mode;
    second_byte_sent_next = second_byte_sent;
    access_finished_next = access_finished;
    received_byte_next = received_byte;
    result = '0;
    result.action = ACT_NONE;
    result.error_code = ERR_NONE;

    if (item.cmd == CMD_START) begin
      read_mode_next = item.is_read;
      if (item.is_read) begin
        transfer_word_next = {pointer_command, item.reg_address};
      end else begin
        transfer_word_next = {item.reg_address, item.write_value};
      end
      second_byte_sent_next = 1'b0;
      access_finished_next = 1'b0;
      result.action = ACT_START;
    end else if (item.timeout_seen) begin
      second_byte_sent_next = 1'b1;
      access_finished_next = 1'b1;
      result.action = ACT_CLR_TIMEOUT;
      result.done_res = 1'b1;
      result.error_code = ERR_TIMEOUT;
    end else begin
      case (item.bus_status)
        ST_START_SENT: begin
          result.action = ACT_SEND;
          result.bus_byte = {slave_address, 1'b0};
        end
        ST_SLA_W_ACK: begin
          result.action = ACT_SEND;
          result.bus_byte = transfer_word[15:8];
        end
        ST_SLA_W_NACK: begin
          // restart the same access from the top
          second_byte_sent_next = 1'b0;
          access_finished_next = 1'b0;
          result.action = ACT_STOP_START;
        end
        ST_DATA_TX_ACK: begin
          if (!second_byte_sent) begin
            result.action = ACT_SEND;
            result.bus_byte = transfer_word[7:0];
            second_byte_sent_next = 1'b1;
          end else if (read_mode) begin
            result.action = ACT_RESTART;
          end else begin
            second_byte_sent_next = 1'b1;
            access_finished_next = 1'b1;
            result.action = ACT_STOP;
            result.done_res = 1'b1;
          end
        end
        ST_RESTART_SENT: begin
          result.action = ACT_SEND;
          result.bus_byte = {slave_address, READ_BIT};
        end
        ST_SLA_R_ACK: begin
          result.action = ACT_RECV;
        end
        ST_DATA_RX_NACK: begin
          received_byte_next = item.rx_byte;
          second_byte_sent_next = 1'b1;
          access_finished_next = 1'b1;
          result.action = ACT_STOP;
          result.done_res = 1'b1;
          result.read_data = item.rx_byte;
        end
        default: begin
          second_byte_sent_next = 1'b1;
          access_finished_next = 1'b1;
          result.done_res = 1'b1;
          result.error_code = ERR_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_word <= '0;
      read_mode <= 1'b0;
      second_byte_sent <= 1'b0;
      access_finished <= 1'b0;
      received_byte <= '0;
    end else if (fire) begin
      transfer_word <= transfer_word_next;
      read_mode <= read_mode_next;
      second_byte_sent <= second_byte_sent_next;
      access_finished <= access_finished_next;
      received_byte <= received_byte_next;
    end
  end

endmodule

### hw/rtl/i2cras_out_stage.sv
// ----------------------------------------------------------------------------
// i2cras_out_stage
// Result register for the response channel.
// ----------------------------------------------------------------------------
module i2cras_out_stage import i2cras_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  input  result_t       load_data,
  output logic          can_take,
  i2cras_rsp_if.source  rsp
);

  logic    out_valid;
  result_t out_data;

  assign can_take = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

### hw/rtl/i2c_register_access_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_top
// I2C master sequencer for single register reads and writes.
//
// req carries either a start command (cmd 0) that latches one register
// access, or one status event (cmd 1) reported by the bus controller.
// For every request one transaction leaves on rsp: the next bus action,
// the byte to load, and done, error code and read data.
// cfg writes the slave address (index 0) and the pointer command
// (index 1); it is always ready and should be used while the block idles.
// The request is held in the input register, is decoded, and is loaded
// into the result register, which drives rsp. One request is taken every
// cycle while rsp keeps taking results; the state update in the decode
// stage is a single short next-state rule, so back-to-back requests see it.
// When rsp stalls, the result register and the input register hold, and
// req ready drops only once both are full.
// Reset clears both stages, the access state, and loads the default
// slave address and pointer command.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_top import i2cras_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  i2cras_req_if.sink   req,
  i2cras_rsp_if.source rsp,
  i2cras_cfg_if.sink   cfg
);

  stage_t  stage;
  logic    can_take;
  logic    fire;
  result_t result;

  assign fire = stage.valid && can_take;

  i2cras_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .take  (fire),
    .stage (stage)
  );

  i2cras_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (stage.item),
    .result (result)
  );

  i2cras_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage.valid),
    .load_data  (result),
    .can_take   (can_take),
    .rsp        (rsp)
  );

endmodule

### bench/i2c_register_access_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_top_test
// Self-checking bench for the register access sequencer. Directed accesses
// cover the corner cases first. Random well-formed read and write accesses
// then run with injected NACKs, timeouts, bad status codes and noise events,
// under several slave address and pointer command settings. A scoreboard
// predicts every response and checks them in order.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_top_test;
  import i2cras_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam logic [7:0] KNOWN_STATUS [7] = '{ST_START_SENT, ST_RESTART_SENT, ST_SLA_W_ACK,
    ST_SLA_W_NACK, ST_DATA_TX_ACK, ST_SLA_R_ACK, ST_DATA_RX_NACK};

  class access_scoreboard;
    logic [6:0]  slave_addr;
    logic [7:0]  pointer_cmd;
    logic [15:0] xfer_word;
    logic        read_access;
    logic        low_byte_sent;
    logic        finished;
    logic [7:0]  last_rx;
    result_t     pending_actions[$];
    int          fail_count;
    int          requests, starts, writes_done, reads_done;
    int          timeouts, bad_status, nack_restarts, cfg_writes;

    function new();
      slave_addr = SLAVE_ADDRESS_RST;
      pointer_cmd = POINTER_COMMAND_RST;
      xfer_word = '0;
      read_access = 1'b0;
      low_byte_sent = 1'b0;
      finished = 1'b0;
      last_rx = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      cfg_writes++;
      case (idx)
        CFG_SLAVE_ADDRESS: slave_addr = value[6:0];
        CFG_POINTER_COMMAND: pointer_cmd = value;
        default: ;
      endcase
    endfunction

    function void note_request(item_t it);
      result_t r;
      r = '0;
      requests++;
      if (it.cmd == CMD_START) begin
        read_access = it.is_read;
        xfer_word = it.is_read ? {pointer_cmd, it.reg_address}
                               : {it.reg_address, it.write_value};
        low_byte_sent = 1'b0;
        finished = 1'b0;
        r.action = ACT_START;
        starts++;
      end else if (it.timeout_seen) begin
        // timeout wins over whatever status came with it
        low_byte_sent = 1'b1;
        finished = 1'b1;
        r.action = ACT_CLR_TIMEOUT;
        r.done_res = 1'b1;
        r.error_code = ERR_TIMEOUT;
        timeouts++;
      end else begin
        case (it.bus_status)
          ST_START_SENT: begin
            r.action = ACT_SEND;
            r.bus_byte = {slave_addr, 1'b0};
          end
          ST_SLA_W_ACK: begin
            r.action = ACT_SEND;
            r.bus_byte = xfer_word[15:8];
          end
          ST_SLA_W_NACK: begin
            low_byte_sent = 1'b0;
            finished = 1'b0;
            r.action = ACT_STOP_START;
            nack_restarts++;
          end
          ST_DATA_TX_ACK: begin
            if (!low_byte_sent) begin
              r.action = ACT_SEND;
              r.bus_byte = xfer_word[7:0];
              low_byte_sent = 1'b1;
            end else if (read_access) begin
              r.action = ACT_RESTART;
            end else begin
              finished = 1'b1;
              r.action = ACT_STOP;
              r.done_res = 1'b1;
              writes_done++;
            end
          end
          ST_RESTART_SENT: begin
            r.action = ACT_SEND;
            r.bus_byte = {slave_addr, READ_BIT};
          end
          ST_SLA_R_ACK: r.action = ACT_RECV;
          ST_DATA_RX_NACK: begin
            last_rx = it.rx_byte;
            low_byte_sent = 1'b1;
            finished = 1'b1;
            r.action = ACT_STOP;
            r.done_res = 1'b1;
            r.read_data = last_rx;
            reads_done++;
          end
          default: begin
            low_byte_sent = 1'b1;
            finished = 1'b1;
            r.action = ACT_NONE;
            r.done_res = 1'b1;
            r.error_code = ERR_STATUS;
            bad_status++;
          end
        endcase
      end
      pending_actions.push_back(r);
    endfunction

    function void check_response(result_t got);
      result_t want;
      if (pending_actions.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: response with nothing expected: %s %0d byte %02h done %0d err %0d rd %02h",
                   $time, "action", got.action, got.bus_byte, got.done_res, got.error_code,
                   got.read_data);
        return;
      end
      want = pending_actions.pop_front();
      if (got.action !== want.action || got.bus_byte !== want.bus_byte ||
          got.done_res !== want.done_res || got.error_code !== want.error_code ||
          got.read_data !== want.read_data) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch exp action %0d byte %02h done %0d err %0d rd %02h", $time,
                   want.action, want.bus_byte, want.done_res, want.error_code, want.read_data);
          $display("%0t:          got action %0d byte %02h done %0d err %0d rd %02h", $time,
                   got.action, got.bus_byte, got.done_res, got.error_code, got.read_data);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  i2cras_req_if req_bus();
  i2cras_rsp_if rsp_bus();
  i2cras_cfg_if cfg_bus();

  i2c_register_access_sequencer_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  access_scoreboard sb;
  int  cycles;
  int  items_sent;
  bit  idle_source;
  bit  idle_sink;
  bit  sink_hold;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // every transaction is seen here, on the edge where it is taken
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_register(cfg_bus.index, cfg_bus.data);
      if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.data);
      if (rsp_bus.valid && rsp_bus.ready) sb.check_response(rsp_bus.data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t start_item(logic rd, logic [7:0] reg_addr, logic [7:0] value);
    item_t it;
    it.cmd = CMD_START;
    it.is_read = rd;
    it.reg_address = reg_addr;
    it.write_value = value;
    // event fields carry junk on a start
    it.bus_status = 8'($urandom_range(0, 255));
    it.timeout_seen = 1'($urandom_range(0, 1));
    it.rx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t event_item(logic [7:0] status, logic tmo, logic [7:0] rx);
    item_t it;
    it.cmd = CMD_EVENT;
    it.is_read = 1'($urandom_range(0, 1));
    it.reg_address = 8'($urandom_range(0, 255));
    it.write_value = 8'($urandom_range(0, 255));
    it.bus_status = status;
    it.timeout_seen = tmo;
    it.rx_byte = rx;
    return it;
  endfunction

  // valid stays up across back-to-back items, drops only for a gap
  task automatic send_request(item_t it);
    int gap;
    req_bus.data <= it;
    req_bus.valid <= 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    items_sent++;
    gap = idle_source ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one edge first so the last accepted request is already noted
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_actions.size() != 0);
  endtask

  task automatic write_config(logic [7:0] sa, logic [7:0] pc);
    cfg_bus.index <= CFG_SLAVE_ADDRESS;
    cfg_bus.data <= sa;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.index <= CFG_POINTER_COMMAND;
    cfg_bus.data <= pc;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // one access with random content, sometimes broken on the way
  task automatic play_access();
    logic       rd;
    logic [7:0] status;
    int         flow_len;
    int         k;
    int         r;
    rd = 1'($urandom_range(0, 1));
    flow_len = rd ? 7 : 4;
    send_request(start_item(rd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    k = 0;
    while (k < flow_len) begin
      case (k)
        0: status = ST_START_SENT;
        1: status = ST_SLA_W_ACK;
        2, 3: status = ST_DATA_TX_ACK;
        4: status = ST_RESTART_SENT;
        5: status = ST_SLA_R_ACK;
        default: status = ST_DATA_RX_NACK;
      endcase
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_request(event_item(status, 1'b1, 8'($urandom_range(0, 255))));
        break;
      end else if (r < 4) begin
        send_request(event_item(8'($urandom_range(0, 255)), 1'b0,
                                8'($urandom_range(0, 255))));
        break;
      end else if (r < 9 && k == 1) begin
        // address NACK, controller retries from the start condition
        send_request(event_item(ST_SLA_W_NACK, 1'b0, 8'($urandom_range(0, 255))));
        k = 0;
      end else begin
        send_request(event_item(status, 1'b0, 8'($urandom_range(0, 255))));
        k++;
      end
    end
  endtask

  task automatic run_traffic(int count);
    int target;
    int r;
    logic [7:0] status;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        status = ($urandom_range(0, 1) == 1) ? KNOWN_STATUS[3'($urandom_range(0, 6))]
                                             : 8'($urandom_range(0, 255));
        send_request(event_item(status, $urandom_range(0, 19) == 0,
                                8'($urandom_range(0, 255))));
      end else if (r < 16) begin
        send_request(start_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255))));
      end else begin
        play_access();
      end
    end
  endtask

  // response side, with an occasional long hold-off on request
  initial begin
    int gap;
    rsp_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else if (!idle_sink) begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          rsp_bus.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          rsp_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    idle_source = 1'b1;
    idle_sink = 1'b1;
    sink_hold = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part with reset configuration
    send_request(event_item(ST_START_SENT, 1'b0, 8'hFF));
    send_request(start_item(1'b0, 8'hFF, 8'h00));
    send_request(event_item(ST_START_SENT, 1'b0, 8'h00));
    send_request(event_item(ST_SLA_W_ACK, 1'b0, 8'hFF));
    send_request(event_item(ST_DATA_TX_ACK, 1'b0, 8'h00));
    send_request(event_item(ST_DATA_TX_ACK, 1'b0, 8'hFF));
    // one more data ack after the write has finished
    send_request(event_item(ST_DATA_TX_ACK, 1'b0, 8'h00));
    send_request(start_item(1'b1, 8'h00, 8'hFF));
    send_request(event_item(ST_START_SENT, 1'b0, 8'h00));
    send_request(event_item(ST_SLA_W_ACK, 1'b0, 8'h00));
    send_request(event_item(ST_DATA_TX_ACK, 1'b0, 8'h00));
    send_request(event_item(ST_DATA_TX_ACK, 1'b0, 8'h00));
    send_request(event_item(ST_RESTART_SENT, 1'b0, 8'h00));
    send_request(event_item(ST_SLA_R_ACK, 1'b0, 8'h00));
    send_request(event_item(ST_DATA_RX_NACK, 1'b0, 8'hFF));
    send_request(start_item(1'b0, 8'h5A, 8'hA5));
    send_request(event_item(ST_START_SENT, 1'b0, 8'h12));
    send_request(event_item(ST_SLA_W_NACK, 1'b0, 8'h34));
    send_request(event_item(ST_START_SENT, 1'b0, 8'h56));
    send_request(event_item(ST_SLA_W_ACK, 1'b0, 8'h78));
    // a new start replaces the access in flight
    send_request(start_item(1'b1, 8'h3C, 8'hC3));
    send_request(event_item(ST_DATA_TX_ACK, 1'b1, 8'h9A));
    send_request(event_item(8'hFF, 1'b0, 8'hBC));
    send_request(event_item(8'h00, 1'b0, 8'hDE));
    send_request(event_item(ST_DATA_RX_NACK, 1'b0, 8'h00));
    drain();

    // lowest settings, bit 7 of the address write must be dropped
    write_config(8'h80, 8'h00);
    run_traffic(350);
    drain();

    // highest settings, receiver holds off while requests keep coming
    write_config(8'h7F, 8'hFF);
    idle_source = 1'b0;
    sink_hold = 1'b1;
    run_traffic(350);
    idle_source = 1'b1;
    drain();

    // full rate on both sides
    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    idle_source = 1'b0;
    idle_sink = 1'b0;
    run_traffic(400);
    idle_source = 1'b1;
    idle_sink = 1'b1;
    drain();

    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_traffic(400);
    drain();

    write_config({1'b0, SLAVE_ADDRESS_RST}, POINTER_COMMAND_RST);
    run_traffic(400);
    drain();

    repeat (8) @(posedge clk);
    if (sb.pending_actions.size() != 0) begin
      sb.fail_count += sb.pending_actions.size();
      $display("%0d expected responses never arrived", sb.pending_actions.size());
    end

    $display("covered %0d requests: %0d accesses started, %0d writes and %0d reads completed",
             sb.requests, sb.starts, sb.writes_done, sb.reads_done);
    $display("%0d timeouts, %0d bad status codes, %0d address NACK retries, %0d config writes",
             sb.timeouts, sb.bad_status, sb.nack_restarts, sb.cfg_writes);
    if (sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
